// File: sv/ghbdc_pkg.sv
// Shared constants and controller/datapath interface types for the GHB delta prefetcher.
`timescale 1ns / 1ps
`default_nettype none
package ghbdc_pkg;

  localparam int TABLE_ENTRIES_DEF = 256;
  localparam int RING_ENTRIES_DEF  = 256;
  localparam int WALK_DEPTH_DEF    = 16;
  localparam int MAX_DEGREE_DEF    = 4;

  // Positions at the tail of the delta history that are not tried as the start of a candidate pair.
  localparam int PAIR_TRIM = 4;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 5;

  localparam logic [CFG_INDEX_W-1:0] REG_ISSUE_DEGREE = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_MSHR_LIMIT   = 2'd1;

  localparam logic [2:0] ISSUE_DEGREE_RST = 3'd4;
  localparam logic [4:0] MSHR_LIMIT_RST   = 5'd4;

  typedef struct packed {
    logic load;
    logic scan;
    logic append;
    logic walk_rd;
    logic walk_cmp;
    logic match;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic scan_done;
    logic found;
    logic walk_go;
    logic walk_stop;
    logic walk_last;
    logic match_hit;
    logic match_end;
    logic mshr_ok;
    logic emit_go;
    logic emit_more;
  } status_t;

endpackage
`default_nettype wire

// File: sv/ghbdc_ctrl.sv
// Sequencing state machine for the GHB delta prefetcher.
`timescale 1ns / 1ps
`default_nettype none
module ghbdc_ctrl #(
  parameter int WALK_DEPTH = ghbdc_pkg::WALK_DEPTH_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  output logic                   busy,
  output ghbdc_pkg::cmd_t        cmd,
  input  wire ghbdc_pkg::status_t st
);
  import ghbdc_pkg::*;

  localparam int MATCH_POS = WALK_DEPTH - PAIR_TRIM;

  typedef enum logic [6:0] {
    S_IDLE     = 7'b0000001,
    S_SCAN     = 7'b0000010,
    S_APPEND   = 7'b0000100,
    S_WALK_RD  = 7'b0001000,
    S_WALK_CMP = 7'b0010000,
    S_MATCH    = 7'b0100000,
    S_EMIT     = 7'b1000000
  } state_t;

  state_t state, state_next;
  state_t walk_exit;

  assign walk_exit = (MATCH_POS > 0) ? S_MATCH : S_IDLE;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) state_next = S_SCAN;
      end
      S_SCAN: begin
        if (st.scan_done) state_next = S_APPEND;
      end
      S_APPEND: begin
        state_next = st.found ? S_WALK_RD : S_IDLE;
      end
      S_WALK_RD: begin
        state_next = st.walk_go ? S_WALK_CMP : walk_exit;
      end
      S_WALK_CMP: begin
        state_next = (st.walk_stop || st.walk_last) ? walk_exit : S_WALK_RD;
      end
      S_MATCH: begin
        if (st.match_hit) state_next = st.mshr_ok ? S_EMIT : S_IDLE;
        else if (st.match_end) state_next = S_IDLE;
      end
      S_EMIT: begin
        if (!st.emit_go || !st.emit_more) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign busy         = (state != S_IDLE);
  assign cmd.load     = (state == S_IDLE) && start;
  assign cmd.scan     = (state == S_SCAN);
  assign cmd.append   = (state == S_APPEND);
  assign cmd.walk_rd  = (state == S_WALK_RD);
  assign cmd.walk_cmp = (state == S_WALK_CMP);
  assign cmd.match    = (state == S_MATCH);
  assign cmd.emit     = (state == S_EMIT);

  a_load_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> (state == S_SCAN))
    else $error("accepted word did not start a table scan");
  a_append_after_scan: assert property (@(posedge clk) disable iff (rst)
    (state == S_APPEND) |-> ($past(state) == S_SCAN))
    else $error("append reached without a finished scan");
  a_emit_needs_mshr: assert property (@(posedge clk) disable iff (rst)
    ((state == S_MATCH) && st.match_hit && !st.mshr_ok) |=> (state == S_IDLE))
    else $error("prefetch run started while MSHRs were busy");

endmodule
`default_nettype wire

// File: sv/ghbdc_datapath.sv
// Index table, history ring, delta history and prefetch address generation.
`timescale 1ns / 1ps
`default_nettype none
module ghbdc_datapath #(
  parameter int TABLE_ENTRIES = ghbdc_pkg::TABLE_ENTRIES_DEF,
  parameter int RING_ENTRIES  = ghbdc_pkg::RING_ENTRIES_DEF,
  parameter int WALK_DEPTH    = ghbdc_pkg::WALK_DEPTH_DEF,
  parameter int MAX_DEGREE    = ghbdc_pkg::MAX_DEGREE_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire ghbdc_pkg::cmd_t                     cmd,
  output ghbdc_pkg::status_t                       st,
  input  wire logic                                cfg_valid,
  input  wire logic [ghbdc_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  wire logic [ghbdc_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  wire logic [63:0]                         access_addr,
  input  wire logic [63:0]                         pc,
  input  wire logic [4:0]                          mshr_occupancy,
  output logic                                     prefetch_valid,
  output logic [63:0]                              prefetch_addr,
  output logic                                     last_of_run
);
  import ghbdc_pkg::*;

  localparam int TW  = $clog2(TABLE_ENTRIES);
  localparam int TCW = $clog2(TABLE_ENTRIES + 1);
  localparam int RW  = $clog2(RING_ENTRIES);
  localparam int WIW = $clog2(WALK_DEPTH);
  localparam int EW  = $clog2(WALK_DEPTH + 1);
  localparam int NW  = $clog2(MAX_DEGREE + 1);
  localparam int MATCH_POS = WALK_DEPTH - PAIR_TRIM;

  localparam logic [TCW-1:0] TABLE_END   = TCW'(TABLE_ENTRIES);
  localparam logic [TW-1:0]  TABLE_LAST  = TW'(TABLE_ENTRIES - 1);
  localparam logic [RW-1:0]  RING_LAST   = RW'(RING_ENTRIES - 1);
  localparam logic [WIW-1:0] WALK_TOP    = WIW'(WALK_DEPTH - 1);
  localparam logic [WIW-1:0] MATCH_LAST  = WIW'((MATCH_POS > 0) ? MATCH_POS - 1 : 0);
  localparam logic [EW-1:0]  WALK_END    = EW'(WALK_DEPTH);

  // Configuration registers.
  logic [2:0] issue_degree;
  logic [4:0] mshr_limit;
  always_ff @(posedge clk) begin
    if (rst) begin
      issue_degree <= ISSUE_DEGREE_RST;
      mshr_limit   <= MSHR_LIMIT_RST;
    end else if (cfg_valid) begin
      if (cfg_index == REG_ISSUE_DEGREE) issue_degree <= cfg_data[2:0];
      else if (cfg_index == REG_MSHR_LIMIT) mshr_limit <= cfg_data;
    end
  end

  logic [NW-1:0] degree;
  assign degree = (32'(issue_degree) > MAX_DEGREE) ? NW'(MAX_DEGREE) : NW'(issue_degree);

  // Captured input word.
  logic [63:0] addr_r, pc_r;
  logic [4:0]  occ_r;
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      addr_r <= access_addr;
      pc_r   <= pc;
      occ_r  <= mshr_occupancy;
    end
  end

  // Index table: PC and newest ring slot in memories, valid bits in flops.
  logic [63:0]    table_pc [TABLE_ENTRIES];
  logic [RW-1:0]  table_newest [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] table_valid;
  logic [TW-1:0]  fifo_head;

  logic [TCW-1:0] scan_addr;
  logic           scan_issue;
  logic           cmp_vld, tv_q, found;
  logic [63:0]    tpc_q;
  logic [RW-1:0]  tnew_q, newest_r;
  logic [TW-1:0]  cmp_idx, hit_idx;
  logic           scan_hit;

  logic [RW-1:0]  ring_head, slot;
  assign slot = (ring_head == RING_LAST) ? '0 : ring_head + RW'(1);

  logic [TW-1:0]  tw_idx;
  assign tw_idx = found ? hit_idx : fifo_head;

  assign scan_issue = cmd.scan && (scan_addr < TABLE_END);
  assign scan_hit   = cmp_vld && tv_q && (tpc_q == pc_r);

  always_ff @(posedge clk) begin
    if (scan_issue) begin
      tpc_q <= table_pc[scan_addr[TW-1:0]];
    end
    if (cmd.append && !found) begin
      table_pc[fifo_head] <= pc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (scan_issue) begin
      tnew_q <= table_newest[scan_addr[TW-1:0]];
    end
    if (cmd.append) begin
      table_newest[tw_idx] <= slot;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      table_valid <= '0;
      fifo_head   <= '0;
      cmp_vld     <= 1'b0;
      found       <= 1'b0;
      scan_addr   <= '0;
    end else begin
      if (cmd.load) begin
        scan_addr <= '0;
        cmp_vld   <= 1'b0;
        found     <= 1'b0;
      end else if (cmd.scan) begin
        cmp_vld <= scan_issue;
        if (scan_issue) begin
          scan_addr <= scan_addr + TCW'(1);
        end
        if (scan_hit) begin
          found <= 1'b1;
        end
      end
      if (cmd.append && !found) begin
        table_valid[fifo_head] <= 1'b1;
        fifo_head <= (fifo_head == TABLE_LAST) ? '0 : fifo_head + TW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (scan_issue) begin
      tv_q    <= table_valid[scan_addr[TW-1:0]];
      cmp_idx <= scan_addr[TW-1:0];
    end
    if (cmd.scan && scan_hit) begin
      hit_idx  <= cmp_idx;
      newest_r <= tnew_q;
    end
  end

  // History ring.
  logic [63:0]   ring_pc [RING_ENTRIES];
  logic [63:0]   ring_addr [RING_ENTRIES];
  logic [RW-1:0] ring_link [RING_ENTRIES];
  logic [RING_ENTRIES-1:0] ring_link_valid;

  logic [63:0]   ra_q, rp_q;
  logic [RW-1:0] rl_q, cur_link;
  logic          rlv_q, cur_lv;
  logic [63:0]   cur_addr;
  logic [WIW-1:0] widx;

  always_ff @(posedge clk) begin
    if (cmd.append) begin
      ring_pc[slot]   <= pc_r;
      ring_addr[slot] <= addr_r;
      ring_link[slot] <= newest_r;
    end
    if (cmd.walk_rd) begin
      rp_q <= ring_pc[cur_link];
      ra_q <= ring_addr[cur_link];
      rl_q <= ring_link[cur_link];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ring_link_valid <= '0;
      ring_head       <= RING_LAST;
    end else if (cmd.append) begin
      ring_link_valid[slot] <= found;
      ring_head             <= slot;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.walk_rd) begin
      rlv_q <= ring_link_valid[cur_link];
    end
  end

  // Delta history, filled from the newest position downwards.
  logic [63:0] delta [WALK_DEPTH];
  logic        walk_stop;
  assign walk_stop = (ra_q == cur_addr) || (rp_q != pc_r);

  logic [WIW-1:0] mi;
  logic           match_hit;
  assign match_hit = (delta[mi] == delta[WALK_DEPTH-2]) &&
                     (delta[mi + WIW'(1)] == delta[WALK_DEPTH-1]);

  logic [EW-1:0]  eidx, eidx1;
  logic [NW-1:0]  n, n1;
  logic [63:0]    pf, pf_next, d_now, d_nxt;
  logic           emit_go, emit_more;

  assign eidx1 = eidx + EW'(1);
  assign n1    = n + NW'(1);
  assign d_now = (eidx  < WALK_END) ? delta[eidx[WIW-1:0]]  : '0;
  assign d_nxt = (eidx1 < WALK_END) ? delta[eidx1[WIW-1:0]] : '0;
  assign emit_go   = (n < degree)  && (d_now != '0);
  assign emit_more = (n1 < degree) && (d_nxt != '0);
  assign pf_next   = pf + d_now;

  always_ff @(posedge clk) begin
    if (cmd.append) begin
      for (int i = 0; i < WALK_DEPTH; i++) delta[i] <= '0;
      cur_addr <= addr_r;
      cur_link <= newest_r;
      cur_lv   <= found;
      widx     <= WALK_TOP;
      mi       <= '0;
    end else if (cmd.walk_cmp && !walk_stop) begin
      delta[widx] <= cur_addr - ra_q;
      cur_addr    <= ra_q;
      cur_link    <= rl_q;
      cur_lv      <= rlv_q;
      widx        <= widx - WIW'(1);
    end
    if (cmd.match) begin
      mi <= mi + WIW'(1);
      if (match_hit) begin
        eidx <= EW'(mi) + EW'(2);
        n    <= '0;
        pf   <= addr_r;
      end
    end else if (cmd.emit) begin
      eidx <= eidx1;
      n    <= n1;
      pf   <= pf_next;
    end
  end

  // Result register: prefetch_valid marks each prefetch word for a single cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      prefetch_valid <= 1'b0;
    end else begin
      prefetch_valid <= cmd.emit && emit_go;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit && emit_go) begin
      prefetch_addr <= pf_next;
      last_of_run   <= !emit_more;
    end
  end

  assign st.scan_done = scan_hit || ((scan_addr == TABLE_END) && !cmp_vld);
  assign st.found     = found;
  assign st.walk_go   = cur_lv;
  assign st.walk_stop = walk_stop;
  assign st.walk_last = (widx == '0);
  assign st.match_hit = match_hit;
  assign st.match_end = (mi == MATCH_LAST);
  assign st.mshr_ok   = (occ_r < mshr_limit);
  assign st.emit_go   = emit_go;
  assign st.emit_more = emit_more;

  a_single_hit: assert property (@(posedge clk) disable iff (rst)
    (cmd.scan && found) |-> !cmp_vld || !scan_hit || $past(cmd.load))
    else $error("second table hit for one PC");
  a_link_written: assert property (@(posedge clk) disable iff (rst)
    cmd.append |=> (ring_link_valid[ring_head] == found))
    else $error("appended ring slot link flag disagrees with lookup");
  a_emit_nonzero: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit && emit_go) |=> (prefetch_addr != $past(pf)))
    else $error("prefetch issued for a zero delta");

endmodule
`default_nettype wire

// File: sv/ghb_delta_correlation_prefetcher_unit.sv
// Top level of the PC-localised GHB delta-correlating prefetcher.
`timescale 1ns / 1ps
`default_nettype none
// Pulse start with an access while busy is low; the word is captured and busy stays high until
// the access is finished. Each access first scans the index table one entry per cycle, appends
// to the history ring, then walks back link by link with one ring read each, searches the delta
// pair one position per cycle (up to WALK_DEPTH - 4 positions) and issues one prefetch per
// cycle. Prefetches appear on prefetch_addr for exactly one cycle with prefetch_valid high,
// last_of_run marking the final word of an access; there is no back pressure, so the receiver
// must take every word. cfg_ready is always high; write the registers only while busy is low.
module ghb_delta_correlation_prefetcher_unit #(
  parameter int TABLE_ENTRIES = ghbdc_pkg::TABLE_ENTRIES_DEF,
  parameter int RING_ENTRIES  = ghbdc_pkg::RING_ENTRIES_DEF,
  parameter int WALK_DEPTH    = ghbdc_pkg::WALK_DEPTH_DEF,
  parameter int MAX_DEGREE    = ghbdc_pkg::MAX_DEGREE_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [ghbdc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [ghbdc_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  wire logic [63:0]                       access_addr,
  input  wire logic [63:0]                       pc,
  input  wire logic [4:0]                        mshr_occupancy,
  output logic                                   prefetch_valid,
  output logic [63:0]                            prefetch_addr,
  output logic                                   last_of_run
);
  import ghbdc_pkg::*;

  cmd_t    cmd;
  status_t st;

  assign cfg_ready = 1'b1;

  ghbdc_ctrl #(
    .WALK_DEPTH(WALK_DEPTH)
  ) u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .cmd   (cmd),
    .st    (st)
  );

  ghbdc_datapath #(
    .TABLE_ENTRIES(TABLE_ENTRIES),
    .RING_ENTRIES (RING_ENTRIES),
    .WALK_DEPTH   (WALK_DEPTH),
    .MAX_DEGREE   (MAX_DEGREE)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .st             (st),
    .cfg_valid      (cfg_valid && cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .access_addr    (access_addr),
    .pc             (pc),
    .mshr_occupancy (mshr_occupancy),
    .prefetch_valid (prefetch_valid),
    .prefetch_addr  (prefetch_addr),
    .last_of_run    (last_of_run)
  );

  a_result_from_busy: assert property (@(posedge clk) disable iff (rst)
    prefetch_valid |-> $past(busy))
    else $error("prefetch word without an access in progress");
  a_start_takes: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted access did not raise busy");
  a_last_marked: assert property (@(posedge clk) disable iff (rst)
    last_of_run && prefetch_valid |=> !prefetch_valid || $past(start && !busy))
    else $error("word followed the last word of its run");

endmodule
`default_nettype wire
